[design/positional_insert_queue_top_macros.svh]
// ---------------------------------------------------------------------------
// positional_insert_queue_top_macros.svh
// Assertion macros for the positional insert queue; empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef POSITIONAL_INSERT_QUEUE_TOP_MACROS_SVH
`define POSITIONAL_INSERT_QUEUE_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define PIQ_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PIQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define PIQ_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define PIQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

[design/piq_pkg.sv]
// ---------------------------------------------------------------------------
// piq_pkg
// Shared types and constants of the positional insert queue.
// ---------------------------------------------------------------------------
package piq_pkg;

  localparam int PIQ_DEPTH     = 16;
  localparam int PIQ_WORD_BITS = 32;

  // Operation codes
  localparam logic [1:0] OP_PUSH   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_POP    = 2'd2;

  // Per-cell next-value select
  typedef enum logic [1:0] {
    SEL_HOLD,
    SEL_LEFT,
    SEL_RIGHT,
    SEL_LOAD
  } piq_sel_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] word_in;
    logic [4:0]  position;
  } piq_in_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] word_out;
    logic [4:0]  count;
    logic        is_empty;
  } piq_out_t;

  // Decision of the controller for the current beat
  typedef struct packed {
    logic ok;
    logic pop_ok;
  } piq_res_t;

endpackage

[design/piq_chan_if.sv]
// ---------------------------------------------------------------------------
// piq_chan_if
// Valid/ready channel carrying one payload per beat.
// ---------------------------------------------------------------------------
interface piq_chan_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[design/positional_insert_queue_top.sv]
// ---------------------------------------------------------------------------
// positional_insert_queue_top
// Ordered word queue with push, insert at position and pop, built as a row
// of slot cells that shift toward or away from the head.
// ---------------------------------------------------------------------------
//
//  channel  dir  payload                               beat
//  in_ch    in   operation, word_in, position          one operation
//  out_ch   out  ok, word_out, count, is_empty         one result per op
//
//  One beat per clock unless out_ch stalls: all cells load their next value
//  (own, left neighbor, right neighbor or new word) in parallel at the accepting
//  edge; the result is valid in the output register from the next cycle on.
//  in_ch.ready is high while that register is empty or being drained; a
//  result held back by out_ch keeps in_ch stalled until it is taken.
//  Sync reset clears count and output valid only; slots are written before read.
//
`include "positional_insert_queue_top_macros.svh"

module positional_insert_queue_top import piq_pkg::*; #(
  parameter int DEPTH     = PIQ_DEPTH,
  parameter int WORD_BITS = PIQ_WORD_BITS
) (
  input logic        clk,
  input logic        rst,
  piq_chan_if.sink   in_ch,
  piq_chan_if.source out_ch
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int EXT_W = (WORD_BITS > 32) ? WORD_BITS : 32;
  localparam int CE_W  = (CNT_W > 5) ? CNT_W : 5;

  logic                 fire;
  logic                 out_valid;
  piq_out_t             out_pl;
  piq_sel_t             sel [DEPTH];
  piq_res_t             res;
  logic [CNT_W-1:0]     cnt;
  logic [CNT_W-1:0]     cnt_next;
  logic [WORD_BITS-1:0] slot [DEPTH];
  logic [EXT_W-1:0]     w_ext;
  logic [EXT_W-1:0]     h_ext;
  logic [CE_W-1:0]      c_ext;
  logic [WORD_BITS-1:0] load_word;

  // Output stage frees up the same cycle it is drained.
  assign in_ch.ready = !out_valid || out_ch.ready;
  assign fire        = in_ch.valid && in_ch.ready;

  // Word width adapts between the 32-bit port and the slot width.
  assign w_ext     = EXT_W'(in_ch.payload.word_in);
  assign load_word = w_ext[WORD_BITS-1:0];
  assign h_ext     = EXT_W'(slot[0]);
  assign c_ext     = CE_W'(cnt_next);

  piq_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .operation (in_ch.payload.operation),
    .position  (in_ch.payload.position),
    .sel       (sel),
    .res       (res),
    .cnt       (cnt),
    .cnt_next  (cnt_next)
  );

  // Slot row; head is cell 0. Cell 0 never takes its left input and the
  // last cell never takes its right one, so those ends are tied off.
  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
    logic [WORD_BITS-1:0] left_w;
    logic [WORD_BITS-1:0] right_w;

    if (gi == 0) begin : g_head
      assign left_w = load_word;
    end else begin : g_mid_l
      assign left_w = slot[gi-1];
    end

    if (gi == DEPTH - 1) begin : g_tail
      assign right_w = slot[gi];
    end else begin : g_mid_r
      assign right_w = slot[gi+1];
    end

    piq_cell #(
      .WORD_BITS (WORD_BITS)
    ) u_cell (
      .clk   (clk),
      .sel   (sel[gi]),
      .left  (left_w),
      .right (right_w),
      .load  (load_word),
      .slot  (slot[gi])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload; head word is read before the pop shifts it out.
  always_ff @(posedge clk) begin
    if (fire) begin
      out_pl.ok       <= res.ok;
      out_pl.word_out <= res.pop_ok ? h_ext[31:0] : 32'd0;
      out_pl.count    <= c_ext[4:0];
      out_pl.is_empty <= (cnt_next == '0);
    end
  end

  assign out_ch.valid   = out_valid;
  assign out_ch.payload = out_pl;

  // Checks
  `PIQ_ASSERT_IMPL(a_cnt_bound, clk, rst, 1'b1, cnt <= CNT_W'(DEPTH), "count above depth")
  `PIQ_ASSERT_NEXT(a_fire_valid, clk, rst, fire, out_ch.valid, "accepted beat gave no result")
  `PIQ_ASSERT_IMPL(a_rej_word, clk, rst, out_valid && !out_pl.ok, ~|out_pl.word_out, "reject word")
  `PIQ_ASSERT_NEXT(a_rej_hold, clk, rst, fire && !res.ok, $stable(cnt), "reject moved count")

endmodule

[design/piq_cell.sv]
// ---------------------------------------------------------------------------
// piq_cell
// One queue slot; takes its own, left, right or a new word each cycle.
// ---------------------------------------------------------------------------
module piq_cell import piq_pkg::*; #(
  parameter int WORD_BITS = PIQ_WORD_BITS
) (
  input  logic                 clk,
  input  piq_sel_t             sel,
  input  logic [WORD_BITS-1:0] left,
  input  logic [WORD_BITS-1:0] right,
  input  logic [WORD_BITS-1:0] load,
  output logic [WORD_BITS-1:0] slot
);

  always_ff @(posedge clk) begin
    unique case (sel)
      SEL_HOLD:  slot <= slot;
      SEL_LEFT:  slot <= left;
      SEL_RIGHT: slot <= right;
      SEL_LOAD:  slot <= load;
    endcase
  end

endmodule

[design/piq_ctrl.sv]
// ---------------------------------------------------------------------------
// piq_ctrl
// Entry count, accept/reject decision and per-cell select generation.
// ---------------------------------------------------------------------------
module piq_ctrl import piq_pkg::*; #(
  parameter int  DEPTH = PIQ_DEPTH,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  logic [1:0]       operation,
  input  logic [4:0]       position,
  output piq_sel_t         sel [DEPTH],
  output piq_res_t         res,
  output logic [CNT_W-1:0] cnt,
  output logic [CNT_W-1:0] cnt_next
);

  localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

  logic [CMP_W-1:0] cnt_c;
  logic [CMP_W-1:0] pos_c;
  logic [CMP_W-1:0] ins_pos;
  logic             full;
  logic             empty;
  logic             ins_ok;
  logic             pop_ok;

  assign cnt_c = CMP_W'(cnt);
  assign pos_c = CMP_W'(position);
  assign full  = (cnt == CNT_W'(DEPTH));
  assign empty = (cnt == '0);

  always_comb begin
    ins_ok  = 1'b0;
    pop_ok  = 1'b0;
    ins_pos = cnt_c;
    unique case (operation)
      OP_PUSH: begin
        ins_ok = !full;
      end
      OP_INSERT: begin
        ins_ok  = !full && (pos_c <= cnt_c);
        ins_pos = pos_c;
      end
      OP_POP: begin
        pop_ok = !empty;
      end
      default: begin
        ins_ok = 1'b0;
      end
    endcase
  end

  assign res.ok     = ins_ok | pop_ok;
  assign res.pop_ok = pop_ok;

  always_comb begin
    priority if (ins_ok) begin
      cnt_next = cnt + CNT_W'(1);
    end else if (pop_ok) begin
      cnt_next = cnt - CNT_W'(1);
    end else begin
      cnt_next = cnt;
    end
  end

  // Each cell compares its own index against the insert point.
  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_sel
    localparam logic [CMP_W-1:0] IDX = CMP_W'(gi);
    localparam bit HAS_RIGHT = (gi < DEPTH - 1);
    always_comb begin
      sel[gi] = SEL_HOLD;
      priority if (fire && ins_ok) begin
        if (IDX == ins_pos) begin
          sel[gi] = SEL_LOAD;
        end else if (IDX > ins_pos) begin
          sel[gi] = SEL_LEFT;
        end
      end else if (fire && pop_ok && HAS_RIGHT) begin
        sel[gi] = SEL_RIGHT;
      end else begin
        sel[gi] = SEL_HOLD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (fire) begin
      cnt <= cnt_next;
    end
  end

endmodule
